>>> hw/rtl/i2da_pkg.sv
// Shared types, constants and microcode encodings for the decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package i2da_pkg;

   localparam int VALUE_WIDTH_DEF = 32;

   localparam int PC_WIDTH = 3;

   localparam logic [6:0] ASCII_ZERO  = 7'd48;
   localparam logic [6:0] ASCII_MINUS = 7'd45;

   // Microprogram step addresses
   localparam logic [PC_WIDTH-1:0] STEP_WAIT   = 3'd0;
   localparam logic [PC_WIDTH-1:0] STEP_DABBLE = 3'd1;
   localparam logic [PC_WIDTH-1:0] STEP_SIGN   = 3'd2;
   localparam logic [PC_WIDTH-1:0] STEP_SKIP   = 3'd3;
   localparam logic [PC_WIDTH-1:0] STEP_DIGIT  = 3'd4;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_DABBLE,
      OP_SIGN,
      OP_SKIP,
      OP_DIGIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_BITS_MORE,
      COND_LEAD_ZERO,
      COND_DIGITS_MORE
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
      logic                done;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic hold;
      logic req_accept;
      logic bits_more;
      logic lead_zero;
      logic digits_more;
   } status_type;

endpackage

>>> hw/rtl/i2da_ucode_rom.sv
// Microcode ROM: one control word per sequencer step.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_ucode_rom (
   input  logic [i2da_pkg::PC_WIDTH-1:0] pc,
   output i2da_pkg::ucode_word_type      word
);
   import i2da_pkg::*;

   always_comb begin
      case (pc)
         STEP_WAIT:   word = '{op: OP_WAIT,   cond: COND_NO_REQ,      target: STEP_WAIT,   done: 1'b0};
         STEP_DABBLE: word = '{op: OP_DABBLE, cond: COND_BITS_MORE,   target: STEP_DABBLE, done: 1'b0};
         STEP_SIGN:   word = '{op: OP_SIGN,   cond: COND_NONE,        target: STEP_SIGN,   done: 1'b0};
         STEP_SKIP:   word = '{op: OP_SKIP,   cond: COND_LEAD_ZERO,   target: STEP_SKIP,   done: 1'b0};
         STEP_DIGIT:  word = '{op: OP_DIGIT,  cond: COND_DIGITS_MORE, target: STEP_DIGIT,  done: 1'b1};
         default:     word = '{op: OP_WAIT,   cond: COND_NONE,        target: STEP_WAIT,   done: 1'b1};
      endcase
   end

endmodule

>>> hw/rtl/i2da_sequencer.sv
// Step counter with conditional jumps, driven by the microcode ROM.
// Depends on i2da_pkg and i2da_ucode_rom.
`timescale 1ns / 1ps

module i2da_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  i2da_pkg::status_type   status,
   output i2da_pkg::ctrl_type     ctrl
);
   import i2da_pkg::*;

   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;
   ucode_word_type      word;
   logic                cond_true;

   i2da_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (word)
   );

   always_comb begin
      case (word.cond)
         COND_NONE:        cond_true = 1'b0;
         COND_NO_REQ:      cond_true = !status.req_accept;
         COND_BITS_MORE:   cond_true = status.bits_more;
         COND_LEAD_ZERO:   cond_true = status.lead_zero;
         COND_DIGITS_MORE: cond_true = status.digits_more;
         default:          cond_true = 1'b0;
      endcase

      if (status.hold) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = word.target;
      end else if (word.done) begin
         pc_in = STEP_WAIT;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op = word.op;

endmodule

>>> hw/rtl/i2da_datapath.sv
// Datapath: magnitude shifter, BCD shift-add-3 register, digit index and output register.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_datapath #(
   parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  i2da_pkg::ctrl_type            ctrl,
   output i2da_pkg::status_type          status,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [6:0]                    rsp_ascii_char,
   output logic                          rsp_last
);
   import i2da_pkg::*;

   // decimal digits of 2^VALUE_WIDTH, log10(2) ~ 0.30103
   localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BcdWidth  = NumDigits * 4;
   localparam int CntWidth  = $clog2(VALUE_WIDTH + 1);
   localparam int IdxWidth  = $clog2(NumDigits);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BcdWidth-1:0]    bcd_ff, bcd_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [IdxWidth-1:0]    idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [BcdWidth-1:0]    bcd_adj;
   logic [3:0]             cur_digit;
   logic                   out_free;
   logic                   req_accept;
   logic                   load_out;

   assign raw        = req_value;
   assign req_stall  = (ctrl.op != OP_WAIT);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_digit  = bcd_ff[idx_ff*4 +: 4];

   // add 3 to every nibble that is 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      status.req_accept  = req_accept;
      status.bits_more   = (cnt_ff != CntWidth'(1));
      status.lead_zero   = (cur_digit == 4'd0) && (idx_ff != '0);
      status.digits_more = (idx_ff != '0);
      case (ctrl.op)
         OP_SIGN:  status.hold = neg_ff && !out_free;
         OP_DIGIT: status.hold = !out_free;
         default:  status.hold = 1'b0;
      endcase
   end

   always_comb begin
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      bcd_in      = bcd_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      load_out    = 1'b0;
      case (ctrl.op)
         OP_WAIT: begin
            if (req_accept) begin
               neg_in = raw[VALUE_WIDTH-1];
               mag_in = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
               bcd_in = '0;
               cnt_in = CntWidth'(VALUE_WIDTH);
               idx_in = IdxWidth'(NumDigits - 1);
            end
         end
         OP_DABBLE: begin
            bcd_in = {bcd_adj[BcdWidth-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_SIGN: begin
            if (neg_ff && out_free) begin
               load_out    = 1'b1;
               rsp_char_in = ASCII_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         OP_SKIP: begin
            if (status.lead_zero) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         OP_DIGIT: begin
            if (out_free) begin
               load_out    = 1'b1;
               rsp_char_in = ASCII_ZERO + {3'b000, cur_digit};
               rsp_last_in = (idx_ff == '0);
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            load_out = 1'b0;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   // busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input taken again while converting");

   // shift counter never runs dry while shifting
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DABBLE) |-> (cnt_ff != '0))
      else $error("dabble step with empty bit count");

   // the ones digit closes the run
   a_last_on_ones: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIGIT && out_free && idx_ff == '0) |=> (rsp_valid && rsp_last))
      else $error("final digit without last");

   // only digits and the sign ever appear
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == ASCII_MINUS ||
                     (rsp_ascii_char >= ASCII_ZERO && rsp_ascii_char <= ASCII_ZERO + 7'd9)))
      else $error("character outside digit or sign");

endmodule

>>> hw/rtl/integer_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on i2da_pkg, i2da_sequencer, i2da_datapath.
//
// Usage:
//   Input channel (req_valid / req_stall / req_value): one signed two's complement
//   integer per transaction. req_stall is high whenever a conversion is in progress.
//   Result channel (rsp_valid / rsp_stall / rsp_ascii_char / rsp_last): the decimal
//   text, most significant character first, one character per transaction. A
//   negative number leads with '-', zero gives a lone '0', no leading zeros.
//   rsp_last marks the final character of each number.
//   Steps: a microprogram of five steps. Take the input, shift-add-3 binary to BCD
//   conversion over every input bit, the sign step, a skip step that passes over
//   each suppressed leading zero to reach the leading digit, then one emit per digit.
//   One item is converted at a time: a new input is taken only after the last
//   digit of the previous one has been loaded into the output register. The BCD
//   register holds NumDigits digits, 10 at 32 bits.
//   Receiver stall: the result sits in an output register; the sequencer holds on
//   its sign and digit steps until that register is free, nothing is lost or repeated.
//   Reset: synchronous, active high; clears the step counter and the output valid.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [6:0]                    rsp_ascii_char,
   output logic                          rsp_last
);
   import i2da_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // step counter, ROM and jump logic
   i2da_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // magnitude, BCD register, digit index and output register
   i2da_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .status         (status),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

endmodule

>>> sim/tb_integer_to_decimal_ascii_top.sv
// Testbench for the signed integer to decimal ASCII converter: directed corner values,
// then a random mix, each checked character by character against an in-bench predictor.
// Depends on i2da_pkg and integer_to_decimal_ascii_top.
`timescale 1ns / 1ps

module tb_integer_to_decimal_ascii_top;
   import i2da_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 310;
   localparam int LONG_HOLD_CYCLES = 300;  // receiver back pressure stretch
   localparam int LONG_HOLD_AT = 40;       // transactions accepted before the stretch
   localparam int DRAIN_AT_A = 21;         // sender waits for all text here (end of directed)
   localparam int DRAIN_AT_B = 200;
   localparam int QUIET_TAIL = 40;         // last transactions run without idling
   localparam int END_SETTLE = 80;         // longer than one full conversion at 32 bits

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } text_char_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [VW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [6:0]           rsp_ascii_char;
   logic                 rsp_last;

   // Values still to be offered, and the text the converter owes us, oldest first.
   logic signed [VW-1:0] pending_values[$];
   text_char_type        expected_text[$];

   // Driver-private counts (blocking) and their registered copies for other processes.
   int sent_count = 0;
   int chars_predicted = 0;
   int items_accepted = 0;
   int chars_predicted_q = 0;
   int chars_received = 0;
   int stim_total = 0;
   int error_count = 0;

   int  sender_gap = 0;
   int  stall_left = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 1'b0;
   bit  took;
   bit  quiet;

   integer_to_decimal_ascii_top #(.VALUE_WIDTH(VW)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   // Decimal text of one value: optional '-', then digits MS first, last flag on the
   // final digit. Magnitude is formed unsigned so the most negative value is exact.
   function automatic void predict_text(input logic signed [VW-1:0] v);
      logic [VW-1:0] magnitude;
      logic [3:0]    digits[$];
      text_char_type c;
      magnitude = v[VW-1] ? (~v + 1'b1) : v;
      if (v[VW-1]) begin
         c.code = ASCII_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
         chars_predicted++;
      end
      do begin
         digits.push_front(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      foreach (digits[i]) begin
         c.code = ASCII_ZERO + 7'(digits[i]);
         c.last = (i == digits.size() - 1);
         expected_text.push_back(c);
         chars_predicted++;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Sender. valid is held with a steady payload until the transaction is taken; only
   // after that may it drop for a gap, a drain pause, or an empty queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            predict_text(req_value);
            void'(pending_values.pop_front());
            sent_count++;
         end
         items_accepted    <= sent_count;
         chars_predicted_q <= chars_predicted;
         quiet = (sent_count >= stim_total - QUIET_TAIL) || ((sent_count / 50) % 3 == 2);

         if (req_valid && !took) begin
            // keep offering the same transaction
         end else if (sender_gap > 0) begin
            sender_gap <= sender_gap - 1;
            req_valid  <= 1'b0;
         end else if ((sent_count == DRAIN_AT_A || sent_count == DRAIN_AT_B) &&
                      chars_predicted != chars_received) begin
            // wait for the converter to hand back every owed character
            req_valid <= 1'b0;
         end else if (pending_values.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sender_gap <= $urandom_range(1, 10) - 1;
            req_valid  <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_value <= pending_values[0];
         end
      end
   end

   // Receiver back pressure: one long hold early on so the converter backs up onto
   // its input, random bursts elsewhere, none in the quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!long_hold_done && items_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!(items_accepted >= stim_total - QUIET_TAIL ||
                     (items_accepted / 50) % 3 == 2) && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Checker: every accepted character against the oldest one owed.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_received <= chars_received + 1;
         if (expected_text.size() == 0) begin
            report_mismatch("unexpected character", rsp_ascii_char, -1);
         end else begin
            want = expected_text.pop_front();
            if (rsp_ascii_char !== want.code)
               report_mismatch("ascii_char", rsp_ascii_char, want.code);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Stimulus build-up, reset, and end of run.
   initial begin
      longint unsigned pow10[10];
      longint          m;
      int              k;
      int              pick;
      logic signed [VW-1:0] v;

      pow10[0] = 1;
      for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * 10;

      // Directed: zero, single digits, digit-count boundaries, both extremes,
      // the most negative value, alternating bit patterns.
      pending_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999999999,
                         1000000000, -1000000000, 2147483647, -2147483647,
                         32'sh80000000, 2147483646, 123456789, -987654321,
                         32'sh55555555, 32'shAAAAAAAA};

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0, 1: v = $urandom;
            2: v = $signed($urandom_range(0, 200)) - 100;
            3: begin
               // around a power of ten
               k = $urandom_range(1, 9);
               m = longint'(pow10[k]) + $urandom_range(0, 2) - 1;
               v = VW'($urandom_range(0, 1) ? -m : m);
            end
            4: begin
               // uniform digit count
               k = $urandom_range(1, 9);
               m = longint'($urandom % pow10[k]);
               v = VW'($urandom_range(0, 1) ? -m : m);
            end
            default: v = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                                 : 32'sh80000000 + $urandom_range(0, 3);
         endcase
         pending_values.push_back(v);
      end
      stim_total = pending_values.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < stim_total) @(posedge clock);
      while (chars_received != chars_predicted_q) @(posedge clock);
      // any stray character in this window is flagged by the checker
      repeat (END_SETTLE) @(posedge clock);

      if (error_count == 0 && expected_text.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: worst case is far below 2 ms of simulated time.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
